// ===== design/life_pkg.sv =====
`timescale 1ns / 1ps

package life_pkg;

  // request kinds, same encoding in req_type and done_kind
  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2
  } req_kind_e;

  // configuration register indexes
  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;

  localparam logic [6:0] COLS_RESET = 7'd40;
  localparam logic [5:0] ROWS_RESET = 6'd25;
  localparam int unsigned MIN_SIZE  = 3;

  // life rule
  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] cell_row;
    logic [5:0] cell_col;
    logic       cell_in;
  } req_t;

  typedef struct packed {
    logic       cell_out;
    logic [1:0] done_kind;
  } rsp_t;

  // per-row-cell control
  typedef struct packed {
    logic shift;   // rotate this row one place toward row 0
    logic last;    // this cell is the wrap point, takes the new row
    logic wr;      // single-bit write into this row
    logic wr_val;
  } cell_ctl_t;

  // row update engine control
  typedef struct packed {
    logic start;
    logic step;
    logic last;
  } eng_ctl_t;

endpackage

// ===== design/life_automaton_toroidal_step_core.sv =====
`timescale 1ns / 1ps
// Toroidal life grid with single-cell access.
// Request channel (in_valid_i / in_stall_o / in_req_i): write a cell, read a
// cell, or advance one generation. Response channel (out_valid_o /
// out_stall_i / out_rsp_o): one response per request, in order, echoing the
// kind; cell_out carries the read value and is 0 otherwise.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 sets the column count,
// index 1 the row count; always ready. To be written while no request is open:
// the user is bound to this, the block does not enforce it. Read and write
// respond in the cycle after acceptance, one per cycle while no response stalls.
// An advance rotates the rows through the chain of row cells, one row through
// the update engine per cycle, and responds once every row in use has passed
// (sizes clamped to 3..MAX_ROWS / 3..MAX_COLS); then requests are taken again.
// Reset clears every cell at once and loads 40 columns, 25 rows.
// A stalled response holds in the output register; no further request
// is taken until it drains.
module life_automaton_toroidal_step_core import life_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  localparam int unsigned RIW = $clog2(MAX_ROWS);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CIW = $clog2(MAX_COLS);
  localparam int unsigned CCW = $clog2(MAX_COLS + 1);

  typedef enum logic {ST_IDLE, ST_ADV} state_e;

  state_e       state_q;
  logic [RIW-1:0] step_q;
  logic [6:0]   cols_q;
  logic [5:0]   rows_q;
  logic         out_valid_q;
  rsp_t         out_rsp_q;

  logic [RCW-1:0] nrows;
  logic [CCW-1:0] ncols;
  logic [RIW-1:0] last_row, row_idx, sel_row;
  logic [CIW-1:0] last_col, col_idx;
  logic           in_grid, acc, adv_start, adv_last, rd_bit;
  logic [MAX_COLS-1:0] rows [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_row, new_row, wr_mask;
  eng_ctl_t       eng_ctl;

  // clamp sizes
  always_comb begin
    if (32'(rows_q) < MIN_SIZE) begin
      nrows = RCW'(MIN_SIZE);
    end else if (32'(rows_q) > MAX_ROWS) begin
      nrows = RCW'(MAX_ROWS);
    end else begin
      nrows = RCW'(rows_q);
    end
    if (32'(cols_q) < MIN_SIZE) begin
      ncols = CCW'(MIN_SIZE);
    end else if (32'(cols_q) > MAX_COLS) begin
      ncols = CCW'(MAX_COLS);
    end else begin
      ncols = CCW'(cols_q);
    end
  end

  assign last_row = RIW'(nrows - RCW'(1));
  assign last_col = CIW'(ncols - CCW'(1));
  assign in_grid  = (32'(in_req_i.cell_row) < 32'(nrows)) &&
                    (32'(in_req_i.cell_col) < 32'(ncols));
  assign row_idx  = RIW'(in_req_i.cell_row);
  assign col_idx  = CIW'(in_req_i.cell_col);

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign adv_start  = acc && (in_req_i.req_type == REQ_ADVANCE);
  assign adv_last   = (state_q == ST_ADV) && (step_q == last_row);

  // one shared row select: wrap row at advance start, else the addressed row
  assign sel_row = adv_start ? last_row : row_idx;
  assign rd_row  = rows[sel_row];
  assign rd_bit  = in_grid & rd_row[col_idx];
  assign wr_mask = MAX_COLS'(1) << col_idx;

  assign eng_ctl.start = adv_start;
  assign eng_ctl.step  = (state_q == ST_ADV);
  assign eng_ctl.last  = adv_last;

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
    cell_ctl_t ctl;
    assign ctl.shift  = (state_q == ST_ADV) && (32'(i) < 32'(nrows));
    assign ctl.last   = (RIW'(i) == last_row);
    assign ctl.wr     = acc && (in_req_i.req_type == REQ_WRITE) && in_grid &&
                        (RIW'(i) == row_idx);
    assign ctl.wr_val = in_req_i.cell_in;

    life_row_cell #(.W(MAX_COLS)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .nbr_i     (rows[(i+1)%MAX_ROWS]),
      .eng_i     (new_row),
      .wr_mask_i (wr_mask),
      .row_o     (rows[i])
    );
  end

  life_row_engine #(.W(MAX_COLS)) u_engine (
    .clk_i      (clk_i),
    .ctl_i      (eng_ctl),
    .wrap_row_i (rd_row),
    .mid_i      (rows[0]),
    .nxt_i      (rows[1]),
    .last_col_i (last_col),
    .new_o      (new_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (adv_start) begin
            state_q <= ST_ADV;
            step_q  <= '0;
          end
        end
        ST_ADV: begin
          step_q <= step_q + RIW'(1);
          if (adv_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      priority if (adv_last) begin
        out_valid_q <= 1'b1;
      end else if (acc && !adv_start) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (adv_last) begin
        out_rsp_q.cell_out  <= 1'b0;
        out_rsp_q.done_kind <= REQ_ADVANCE;
      end else if (acc && !adv_start) begin
        out_rsp_q.cell_out  <= (in_req_i.req_type == REQ_READ) && rd_bit;
        out_rsp_q.done_kind <= in_req_i.req_type;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_COLS) begin
        cols_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_ROWS) begin
        rows_q <= cfg_data_i[5:0];
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== design/life_row_cell.sv =====
`timescale 1ns / 1ps

module life_row_cell import life_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctl_t     ctl_i,
  input  logic [W-1:0]  nbr_i,
  input  logic [W-1:0]  eng_i,
  input  logic [W-1:0]  wr_mask_i,
  output logic [W-1:0]  row_o
);

  logic [W-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctl_i.shift) begin
      row_q <= ctl_i.last ? eng_i : nbr_i;
    end else if (ctl_i.wr) begin
      row_q <= (row_q & ~wr_mask_i) | (wr_mask_i & {W{ctl_i.wr_val}});
    end
  end

  assign row_o = row_q;

endmodule

// ===== design/life_row_engine.sv =====
`timescale 1ns / 1ps

module life_row_engine import life_pkg::*; #(
  parameter int unsigned W = 64,
  localparam int unsigned CIW = $clog2(W)
) (
  input  logic            clk_i,
  input  eng_ctl_t        ctl_i,
  input  logic [W-1:0]    wrap_row_i,  // row above row 0, loaded at start
  input  logic [W-1:0]    mid_i,       // row being updated
  input  logic [W-1:0]    nxt_i,       // original row below it
  input  logic [CIW-1:0]  last_col_i,
  output logic [W-1:0]    new_o
);

  logic [W-1:0] prev_q;   // original row above the current one
  logic [W-1:0] first_q;  // original row 0, needed by the last row
  logic [W-1:0] up, dn;

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      prev_q  <= wrap_row_i;
      first_q <= mid_i;
    end else if (ctl_i.step) begin
      prev_q  <= mid_i;
    end
  end

  assign up = prev_q;
  assign dn = ctl_i.last ? first_q : nxt_i;

  for (genvar c = 0; c < W; c++) begin : g_col
    logic       in_use, at_last;
    logic       ul, uc, ur, ml, mr, dl, dc, dr;
    logic [3:0] n;

    assign in_use  = CIW'(c) <= last_col_i;
    assign at_last = CIW'(c) == last_col_i;

    if (c == 0) begin : g_first
      assign ul = up[last_col_i];
      assign ml = mid_i[last_col_i];
      assign dl = dn[last_col_i];
    end else begin : g_inner
      assign ul = up[c-1];
      assign ml = mid_i[c-1];
      assign dl = dn[c-1];
    end

    assign uc = up[c];
    assign dc = dn[c];
    assign ur = at_last ? up[0]    : up[(c+1)%W];
    assign mr = at_last ? mid_i[0] : mid_i[(c+1)%W];
    assign dr = at_last ? dn[0]    : dn[(c+1)%W];

    assign n = 4'(ul) + 4'(uc) + 4'(ur) + 4'(ml) + 4'(mr) + 4'(dl) + 4'(dc) + 4'(dr);

    assign new_o[c] = !in_use  ? mid_i[c] :
                      mid_i[c] ? ((n == SURVIVE_LO) || (n == BIRTH_CNT)) :
                                 (n == BIRTH_CNT);
  end

endmodule

// ===== design/life_checker.sv =====
`timescale 1ns / 1ps

module life_checker import life_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input req_t       in_req_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input rsp_t       out_rsp_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [1:0] cfg_index_i,
  input logic [6:0] cfg_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // read, write and unknown kinds respond on the next cycle with their kind
  a_quick_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_req_i.req_type != REQ_ADVANCE)
    |=> out_valid_o && (out_rsp_o.done_kind == $past(in_req_i.req_type)))
    else $error("missing or wrong single-cycle response");

  // an advance blocks the request channel while it runs
  a_adv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_req_i.req_type == REQ_ADVANCE) |=> in_stall_o)
    else $error("request taken during advance");

  // only reads carry a cell value
  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.done_kind != REQ_READ) |-> !out_rsp_o.cell_out)
    else $error("cell_out set on non-read response");

endmodule

bind life_automaton_toroidal_step_core life_checker u_life_checker (.*);

// ===== bench/life_automaton_toroidal_step_core_test.sv =====
`timescale 1ns / 1ps

module life_automaton_toroidal_step_core_test;
  import life_pkg::*;

  localparam int unsigned GRID_ROWS = 32;
  localparam int unsigned GRID_COLS = 64;

  // codes outside the package encodings
  localparam logic [1:0] REQ_UNDEFINED = 2'd3;
  localparam logic [1:0] CFG_UNUSED    = 2'd2;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  req_t       in_req_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rsp_t       out_rsp_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;

  life_automaton_toroidal_step_core #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow copy of the grid and the size registers
  bit         life_grid [GRID_ROWS][GRID_COLS];
  logic [6:0] cols_reg = COLS_RESET;
  logic [5:0] rows_reg = ROWS_RESET;

  req_t        req_q[$];
  rsp_t        rsp_expect_q[$];
  rsp_t        pred_rsp;
  rsp_t        want_rsp;
  int unsigned send_gap_pct = 38;
  int unsigned recv_stall_pct = 53;
  int unsigned fail_count = 0;
  int unsigned req_count = 0;
  int unsigned rsp_count = 0;
  int unsigned generations = 0;
  int unsigned sizes_seen = 1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned cols_eff();
    if (cols_reg < MIN_SIZE) return MIN_SIZE;
    if (cols_reg > GRID_COLS) return GRID_COLS;
    return cols_reg;
  endfunction

  function automatic int unsigned rows_eff();
    if (rows_reg < MIN_SIZE) return MIN_SIZE;
    if (rows_reg > GRID_ROWS) return GRID_ROWS;
    return rows_reg;
  endfunction

  // one life generation over the grid in use; cells outside stay put
  task automatic step_generation();
    int unsigned nr, nc, n, rr, cc;
    bit nxt [GRID_ROWS][GRID_COLS];
    nr = rows_eff();
    nc = cols_eff();
    nxt = life_grid;
    for (int unsigned r = 0; r < nr; r++) begin
      for (int unsigned c = 0; c < nc; c++) begin
        n = 0;
        for (int unsigned i = 0; i < 3; i++) begin
          for (int unsigned j = 0; j < 3; j++) begin
            if (i != 1 || j != 1) begin
              rr = (r + nr + i - 1) % nr;
              cc = (c + nc + j - 1) % nc;
              n += life_grid[rr][cc];
            end
          end
        end
        nxt[r][c] = life_grid[r][c] ? (n == SURVIVE_LO || n == BIRTH_CNT) : (n == BIRTH_CNT);
      end
    end
    life_grid = nxt;
  endtask

  task automatic apply_request(input req_t rq, output rsp_t rs);
    logic in_grid;
    in_grid = (rq.cell_row < rows_eff()) && (rq.cell_col < cols_eff());
    rs = '0;
    rs.done_kind = rq.req_type;
    case (rq.req_type)
      REQ_WRITE: begin
        if (in_grid) life_grid[rq.cell_row][rq.cell_col] = rq.cell_in;
      end
      REQ_READ: begin
        if (in_grid) rs.cell_out = life_grid[rq.cell_row][rq.cell_col];
      end
      REQ_ADVANCE: begin
        step_generation();
        generations++;
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_request(in_req_i, pred_rsp);
        rsp_expect_q.push_back(pred_rsp);
        req_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_req_i   <= req_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (rsp_expect_q.size() == 0) begin
          $error("response with nothing outstanding: cell_out %0b done_kind %0d",
                 out_rsp_o.cell_out, out_rsp_o.done_kind);
          fail_count++;
        end else begin
          want_rsp = rsp_expect_q.pop_front();
          rsp_count++;
          if (out_rsp_o.cell_out !== want_rsp.cell_out) begin
            $error("cell_out mismatch: expected %0b, got %0b",
                   want_rsp.cell_out, out_rsp_o.cell_out);
            fail_count++;
          end
          if (out_rsp_o.done_kind !== want_rsp.done_kind) begin
            $error("done_kind mismatch: expected %0d, got %0d",
                   want_rsp.done_kind, out_rsp_o.done_kind);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic queue_req(input logic [1:0] kind, input int unsigned row,
                           input int unsigned col, input logic val);
    req_t rq;
    rq.req_type = kind;
    rq.cell_row = 5'(row);
    rq.cell_col = 6'(col);
    rq.cell_in  = val;
    req_q.push_back(rq);
  endtask

  // random traffic; most accesses land in a small window so patterns evolve
  task automatic queue_mix(input int unsigned count);
    int unsigned nr, nc, wr0, wc0, roll;
    req_t rq;
    nr  = rows_eff();
    nc  = cols_eff();
    wr0 = $urandom_range(0, nr - 1);
    wc0 = $urandom_range(0, nc - 1);
    for (int unsigned k = 0; k < count; k++) begin
      rq.cell_in = ($urandom_range(0, 99) < 40);
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        rq.cell_row = 5'((wr0 + $urandom_range(0, 5)) % nr);
        rq.cell_col = 6'((wc0 + $urandom_range(0, 5)) % nc);
      end else if (roll < 88) begin
        rq.cell_row = 5'($urandom_range(0, nr - 1));
        rq.cell_col = 6'($urandom_range(0, nc - 1));
      end else begin
        rq.cell_row = 5'($urandom_range(0, GRID_ROWS - 1));
        rq.cell_col = 6'($urandom_range(0, GRID_COLS - 1));
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) rq.req_type = REQ_WRITE;
      else if (roll < 86) rq.req_type = REQ_READ;
      else if (roll < 97) rq.req_type = REQ_ADVANCE;
      else rq.req_type = REQ_UNDEFINED;
      req_q.push_back(rq);
    end
  endtask

  // sender holds off until every response is back; checked mid-cycle so
  // the edge's queue and valid updates have settled
  task automatic drain();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_valid_i || rsp_expect_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == CFG_COLS) cols_reg = val;
    else if (idx == CFG_ROWS) rows_reg = val[5:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [6:0] cols, input logic [6:0] rows,
                           input int unsigned count);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    sizes_seen++;
    queue_mix(count);
    drain();
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    // reset grid is 40 x 25
    queue_req(REQ_READ, 0, 0, 1'b0);
    queue_req(REQ_WRITE, 0, 0, 1'b1);
    queue_req(REQ_READ, 0, 0, 1'b0);
    queue_req(REQ_WRITE, 24, 39, 1'b1);
    queue_req(REQ_READ, 24, 39, 1'b0);
    queue_req(REQ_WRITE, 31, 63, 1'b1);
    queue_req(REQ_READ, 31, 63, 1'b1);
    queue_req(REQ_WRITE, 0, 40, 1'b1);
    queue_req(REQ_READ, 0, 40, 1'b0);
    queue_req(REQ_READ, 25, 0, 1'b0);
    queue_req(REQ_WRITE, 0, 0, 1'b0);
    queue_req(REQ_READ, 0, 0, 1'b0);
    queue_req(REQ_UNDEFINED, 31, 63, 1'b1);
    // vertical blinker through the row wrap at the last column
    queue_req(REQ_WRITE, 0, 39, 1'b1);
    queue_req(REQ_WRITE, 1, 39, 1'b1);
    queue_req(REQ_ADVANCE, 31, 63, 1'b1);
    queue_req(REQ_READ, 0, 0, 1'b0);
    queue_req(REQ_READ, 0, 38, 1'b0);
    queue_req(REQ_READ, 24, 39, 1'b0);
    queue_req(REQ_ADVANCE, 0, 0, 1'b0);
    queue_req(REQ_READ, 24, 39, 1'b0);
    queue_req(REQ_READ, 0, 0, 1'b0);
    drain();

    queue_mix(160);
    drain();
    run_phase(7'd3, 7'd3, 165);
    run_phase(7'd64, 7'd32, 165);

    send_gap_pct   = 53;
    recv_stall_pct = 38;
    run_phase(7'd0, 7'd1, 165);
    write_reg(CFG_UNUSED, 7'd5);
    queue_mix(20);
    drain();
    run_phase(7'd127, 7'd63, 165);
    run_phase(7'd10, 7'd72, 165);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(7'd17, 7'd5, 165);
    run_phase(7'($urandom_range(3, 64)), 7'($urandom_range(3, 32)), 165);
    run_phase(7'd33, 7'd20, 165);

    repeat (40) @(posedge clk_i);
    if (rsp_expect_q.size() != 0) begin
      $error("%0d responses never arrived", rsp_expect_q.size());
      fail_count++;
    end
    $display("Ran %0d requests including %0d generation steps across %0d grid sizes",
             req_count, generations, sizes_seen);
    $display("Checked %0d responses, %0d mismatches", rsp_count, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
